>>> rtl/sfs_pkg.sv
// Shared types, widths and codes for the sprite frame sequencer.
// No dependencies; every other file imports this package.
package sfs_pkg;

    // Field and register widths.
    localparam int ACT_W      = 3;
    localparam int TIME_W     = 32;
    localparam int FRM_W      = 8;
    localparam int DUR_W      = 16;
    localparam int CNT_W      = 9;
    localparam int SPD_W      = 16;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 7;
    localparam int MAX_FRAMES = 256;

    // Animation time is unsigned 40.8 fixed point.
    localparam int FRAC_W = 8;
    localparam int ANIM_W = TIME_W + SPD_W;
    localparam int DIV_W  = ANIM_W - FRAC_W;
    // Ping-pong period 2*(n-1) needs one bit more than the frame count.
    localparam int MOD_W  = CNT_W + 1;

    // Step counters of the serial units.
    localparam int MUL_CW  = $clog2(SPD_W);
    localparam int DIV_CW  = $clog2(DIV_W);
    localparam int GRID_CW = $clog2(FRM_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_DURATION = 3'd0,
        CFG_FRAME_COUNT    = 3'd1,
        CFG_FIRST_FRAME    = 3'd2,
        CFG_REVERSE_DIR    = 3'd3,
        CFG_PLAY_MODE      = 3'd4,
        CFG_SPEED_SCALE    = 3'd5,
        CFG_GRID_COLUMNS   = 3'd6
    } t_cfg_reg;

    // Play modes; the unused code behaves as repeat.
    localparam logic [1:0] PM_REPEAT   = 2'd0;
    localparam logic [1:0] PM_PINGPONG = 2'd1;
    localparam logic [1:0] PM_STOP     = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY     = 3'd0,
        ACT_START     = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_PAUSE     = 3'd3,
        ACT_RESUME    = 3'd4,
        ACT_SET_FRAME = 3'd5,
        ACT_FORCE     = 3'd6,
        ACT_RELEASE   = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV_GO,
        ST_DIV,
        ST_MODE,
        ST_FRAME,
        ST_GRID_GO,
        ST_GRID,
        ST_DONE
    } t_state;

    // Commands to the serial units.
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] mcand;
        logic [SPD_W-1:0]  mplier;
    } t_mul_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DUR_W-1:0] divisor;
        logic [MOD_W-1:0] modulus;
        logic [CNT_W-1:0] count;
        logic [FRM_W-1:0] first;
    } t_div_cmd;

    typedef struct packed {
        logic             start;
        logic [FRM_W-1:0] value;
        logic [COL_W-1:0] columns;
    } t_grid_cmd;

    // Status returned by every serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

>>> rtl/sfs_in_if.sv
// Event channel into the sprite frame sequencer.
// Depends on sfs_pkg for the field widths.
interface sfs_in_if import sfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] sim_time;
    logic [FRM_W-1:0]  frame_value;

    modport source (output valid, action, sim_time, frame_value, input ready);
    modport sink (input valid, action, sim_time, frame_value, output ready);
endinterface

>>> rtl/sfs_out_if.sv
// Result channel out of the sprite frame sequencer.
// Depends on sfs_pkg for the field widths.
interface sfs_out_if import sfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FRM_W-1:0] frame_index;
    logic [FRM_W-1:0] grid_column;
    logic [ROW_W-1:0] grid_row;
    logic             is_running;
    logic             is_paused;
    logic             is_forcing;

    modport source (output valid, frame_index, grid_column, grid_row, is_running,
                    is_paused, is_forcing, input ready);
    modport sink (input valid, frame_index, grid_column, grid_row, is_running,
                  is_paused, is_forcing, output ready);
endinterface

>>> rtl/sfs_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on sfs_pkg for widths and the command and status structs.
module sfs_mul import sfs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mul_cmd            i_cmd,
    output t_unit_sts           o_sts,
    output logic [ANIM_W-1:0]   o_prod
);

    logic [TIME_W-1:0] r_mcand;
    logic [ANIM_W-1:0] r_prod;
    logic [MUL_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W:0]   sum;

    // Add the multiplicand into the upper half when the low bit is set.
    assign sum = {1'b0, r_prod[ANIM_W-1:SPD_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    // Control: step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CW'(SPD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: the product shifts right as the multiplier bits are used.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mcand <= i_cmd.mcand;
            r_prod  <= {TIME_W'(0), i_cmd.mplier};
        end else if (r_busy) begin
            r_prod <= {sum, r_prod[SPD_W-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_prod;

endmodule

>>> rtl/sfs_div.sv
// Restoring divider for the absolute frame, one quotient bit per cycle.
// Each quotient bit also feeds a running remainder modulo the frame period,
// and the first frame offset is reduced modulo the count in the first steps.
// Depends on sfs_pkg for widths and the command and status structs.
module sfs_div import sfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_cmd          i_cmd,
    output t_unit_sts         o_sts,
    output logic [DIV_W-1:0]  o_quo,
    output logic [MOD_W-1:0]  o_mod,
    output logic [CNT_W-1:0]  o_ofs
);

    logic [DIV_W-1:0] r_quo;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_dsr;
    logic [MOD_W-1:0] r_mod;
    logic [MOD_W-1:0] r_dmod;
    logic [CNT_W-1:0] r_ofs;
    logic [CNT_W-1:0] r_cnt_n;
    logic [FRM_W-1:0] r_ff;
    logic [DIV_CW-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DUR_W:0]   t_rem;
    logic [DUR_W:0]   d_rem;
    logic             q_bit;
    logic [MOD_W:0]   t_mod;
    logic [MOD_W:0]   d_mod;
    logic [CNT_W:0]   t_ofs;
    logic [CNT_W:0]   d_ofs;
    logic             ofs_step;

    // One trial subtraction per unit per cycle.
    always_comb begin
        t_rem    = {r_rem, r_quo[DIV_W-1]};
        d_rem    = t_rem - {1'b0, r_dsr};
        q_bit    = (t_rem >= {1'b0, r_dsr});
        t_mod    = {r_mod, q_bit};
        d_mod    = t_mod - {1'b0, r_dmod};
        t_ofs    = {r_ofs, r_ff[FRM_W-1]};
        d_ofs    = t_ofs - {1'b0, r_cnt_n};
        ofs_step = (r_cnt >= DIV_CW'(DIV_W - FRM_W));
    end

    // Control: step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo   <= i_cmd.dividend;
            r_rem   <= '0;
            r_dsr   <= i_cmd.divisor;
            r_mod   <= '0;
            r_dmod  <= i_cmd.modulus;
            r_ofs   <= '0;
            r_cnt_n <= i_cmd.count;
            r_ff    <= i_cmd.first;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
            r_rem <= q_bit ? d_rem[DUR_W-1:0] : t_rem[DUR_W-1:0];
            r_mod <= (t_mod >= {1'b0, r_dmod}) ? d_mod[MOD_W-1:0] : t_mod[MOD_W-1:0];
            if (ofs_step) begin
                r_ff  <= {r_ff[FRM_W-2:0], 1'b0};
                r_ofs <= (t_ofs >= {1'b0, r_cnt_n}) ? d_ofs[CNT_W-1:0] : t_ofs[CNT_W-1:0];
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
    assign o_mod      = r_mod;
    assign o_ofs      = r_ofs;

endmodule

>>> rtl/sfs_grid.sv
// Serial divider that splits a frame number into grid column and row.
// Depends on sfs_pkg for widths and the command and status structs.
module sfs_grid import sfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_grid_cmd         i_cmd,
    output t_unit_sts         o_sts,
    output logic [FRM_W-1:0]  o_column,
    output logic [ROW_W-1:0]  o_row
);

    logic [FRM_W-1:0]   r_quo;
    logic [COL_W-1:0]   r_rem;
    logic [COL_W-1:0]   r_cols;
    logic [GRID_CW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [COL_W:0]     t_rem;
    logic [COL_W:0]     d_rem;
    logic               q_bit;

    always_comb begin
        t_rem = {r_rem, r_quo[FRM_W-1]};
        d_rem = t_rem - {1'b0, r_cols};
        q_bit = (t_rem >= {1'b0, r_cols});
    end

    // Control: step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= GRID_CW'(FRM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: restoring division, one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo  <= i_cmd.value;
            r_rem  <= '0;
            r_cols <= i_cmd.columns;
        end else if (r_busy) begin
            r_quo <= {r_quo[FRM_W-2:0], q_bit};
            r_rem <= q_bit ? d_rem[COL_W-1:0] : t_rem[COL_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    // The column is at most the frame number, and at least two columns keep the row narrow.
    assign o_column   = r_rem[FRM_W-1:0];
    assign o_row      = r_quo[ROW_W-1:0];

endmodule

>>> rtl/sprite_frame_sequencer_top.sv
// A time-advancing query or a set frame passes the 16-step multiplier,
// then the 40-step frame divider; other events use the frame divider alone, which is skipped
// when a frame is forced after the event; the 8-step grid divider is in every path.
// One event is in flight at a time; the next is taken the cycle after its result is
// placed in the output register, even if that result has not yet been transferred.
// Synchronous active-low reset restores register defaults and control state; no sweep.
module sprite_frame_sequencer_top import sfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sfs_in_if.sink                i_in,
    sfs_out_if.source             o_out
);

    // Configuration registers.
    logic [DUR_W-1:0] r_cfg_dur;
    logic [CNT_W-1:0] r_cfg_cnt;
    logic [FRM_W-1:0] r_cfg_first;
    logic             r_cfg_rev;
    logic [1:0]       r_cfg_mode;
    logic [SPD_W-1:0] r_cfg_speed;
    logic [COL_W-1:0] r_cfg_cols;

    // Sequencer state.
    t_state            r_state, n_state;
    logic              r_running;
    logic              r_paused;
    logic              r_force;
    logic [FRM_W-1:0]  r_forced;
    logic [TIME_W-1:0] r_last;
    logic [ANIM_W-1:0] r_anim;
    logic              r_set;
    logic [FRM_W-1:0]  r_m;
    logic [FRM_W-1:0]  r_idx;

    // Output register.
    logic              r_out_valid;
    logic [FRM_W-1:0]  r_out_frame;
    logic [FRM_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_run;
    logic              r_out_pause;
    logic              r_out_force;

    // Effective register values.
    logic [DUR_W-1:0]  dur_eff;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  nm1;
    logic [COL_W-1:0]  cols_eff;
    logic [MOD_W-1:0]  d_mod;
    logic              pingpong;

    // Control.
    logic              acc;
    t_action           act;
    logic              need_adv;
    logic              need_set;
    logic              force_after;
    logic              out_load;
    logic              div_go;
    logic              grid_go;
    logic [FRM_W-1:0]  grid_val;

    // Unit connections.
    t_mul_cmd          mul_cmd;
    t_div_cmd          div_cmd;
    t_grid_cmd         grid_cmd;
    t_unit_sts         mul_sts;
    t_unit_sts         div_sts;
    t_unit_sts         grid_sts;
    logic [ANIM_W-1:0] mul_prod;
    logic [DIV_W-1:0]  div_quo;
    logic [MOD_W-1:0]  div_mod;
    logic [CNT_W-1:0]  div_ofs;
    logic [FRM_W-1:0]  grid_col;
    logic [ROW_W-1:0]  grid_row;

    // Datapath intermediates.
    logic [ANIM_W:0]   anim_sum;
    logic [MOD_W-1:0]  pp_q;
    logic [MOD_W-1:0]  pp_m;
    logic              a_zero;
    logic              a_big;
    logic [FRM_W-1:0]  m_val;
    logic [CNT_W:0]    f_sum;
    logic [CNT_W:0]    f_dif;
    logic [FRM_W-1:0]  f_val;

    // Out-of-range register values are folded into their legal range here.
    always_comb begin
        dur_eff = (r_cfg_dur == '0) ? DUR_W'(1) : r_cfg_dur;
        if (r_cfg_cnt == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_cfg_cnt > CNT_W'(MAX_FRAMES)) begin
            n_eff = CNT_W'(MAX_FRAMES);
        end else begin
            n_eff = r_cfg_cnt;
        end
        nm1      = n_eff - CNT_W'(1);
        cols_eff = (r_cfg_cols < COL_W'(2)) ? COL_W'(2) : r_cfg_cols;
        pingpong = (r_cfg_mode == PM_PINGPONG);
        // Ping-pong repeats every 2*(n-1) frames; a single frame keeps the plain count.
        if (pingpong && (n_eff != CNT_W'(1))) begin
            d_mod = ({1'b0, n_eff} << 1) - MOD_W'(2);
        end else begin
            d_mod = MOD_W'(n_eff);
        end
    end

    // Event decode.
    assign acc        = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign act        = t_action'(i_in.action);

    always_comb begin
        need_adv    = (act == ACT_QUERY) && !r_force && r_running && !r_paused;
        need_set    = (act == ACT_SET_FRAME);
        force_after = (act == ACT_FORCE) || ((act != ACT_RELEASE) && r_force);
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit launches.
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        div_go   = 1'b0;
        grid_go  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (need_adv || need_set) begin
                        n_state = ST_MUL;
                    end else if (force_after) begin
                        n_state = ST_GRID_GO;
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_MUL: begin
                if (mul_sts.done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = r_force ? ST_GRID_GO : ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_go  = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    n_state = ST_MODE;
                end
            end
            ST_MODE: begin
                n_state = ST_FRAME;
            end
            ST_FRAME: begin
                n_state = ST_GRID_GO;
            end
            ST_GRID_GO: begin
                grid_go = 1'b1;
                n_state = ST_GRID;
            end
            ST_GRID: begin
                if (grid_sts.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Multiplier: elapsed time times speed, or frame number times duration.
    always_comb begin
        mul_cmd.start  = acc && (need_adv || need_set);
        mul_cmd.mcand  = need_set ? TIME_W'(dur_eff) : (i_in.sim_time - r_last);
        mul_cmd.mplier = need_set ? SPD_W'(i_in.frame_value) : r_cfg_speed;
    end

    sfs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mul_cmd),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    // Time advance saturates at the top of the 40.8 range.
    assign anim_sum = {1'b0, r_anim} + {1'b0, mul_prod};

    // Frame divider: a stopped animation always sits on absolute frame zero.
    always_comb begin
        div_cmd.start    = div_go;
        div_cmd.dividend = r_running ? r_anim[ANIM_W-1:FRAC_W] : '0;
        div_cmd.divisor  = dur_eff;
        div_cmd.modulus  = d_mod;
        div_cmd.count    = n_eff;
        div_cmd.first    = r_cfg_first;
    end

    sfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_sts   (div_sts),
        .o_quo   (div_quo),
        .o_mod   (div_mod),
        .o_ofs   (div_ofs)
    );

    // Play mode applied to the absolute frame.
    always_comb begin
        a_zero = (div_quo == '0);
        a_big  = (div_quo[DIV_W-1:CNT_W] != '0) || (div_quo[CNT_W-1:0] >= n_eff);
        // Ping-pong: position of (a-1) within the period, then fold the back half.
        pp_q   = (div_mod == '0) ? (d_mod - MOD_W'(1)) : (div_mod - MOD_W'(1));
        pp_m   = (pp_q < MOD_W'(nm1)) ? (pp_q + MOD_W'(1)) : (d_mod - MOD_W'(1) - pp_q);
        unique case (r_cfg_mode)
            PM_PINGPONG: begin
                m_val = ((n_eff == CNT_W'(1)) || a_zero) ? '0 : pp_m[FRM_W-1:0];
            end
            PM_STOP: begin
                m_val = a_big ? nm1[FRM_W-1:0] : div_quo[FRM_W-1:0];
            end
            default: begin
                m_val = div_mod[FRM_W-1:0];
            end
        endcase
    end

    // Start offset added forward or backward modulo the frame count.
    always_comb begin
        if (r_cfg_rev) begin
            f_sum = {1'b0, div_ofs} + {1'b0, n_eff} - (CNT_W + 1)'(r_m);
        end else begin
            f_sum = {1'b0, div_ofs} + (CNT_W + 1)'(r_m);
        end
        f_dif = f_sum - {1'b0, n_eff};
        f_val = (f_sum >= {1'b0, n_eff}) ? f_dif[FRM_W-1:0] : f_sum[FRM_W-1:0];
    end

    // Grid split of the shown frame.
    assign grid_val = r_force ? r_forced : r_idx;

    always_comb begin
        grid_cmd.start   = grid_go;
        grid_cmd.value   = grid_val;
        grid_cmd.columns = cols_eff;
    end

    sfs_grid u_grid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (grid_cmd),
        .o_sts    (grid_sts),
        .o_column (grid_col),
        .o_row    (grid_row)
    );

    // Configuration, control flags, timing state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dur   <= DUR_W'(1000);
            r_cfg_cnt   <= CNT_W'(1);
            r_cfg_first <= '0;
            r_cfg_rev   <= 1'b0;
            r_cfg_mode  <= PM_REPEAT;
            r_cfg_speed <= SPD_W'(256);
            r_cfg_cols  <= COL_W'(2);
            r_running   <= 1'b0;
            r_paused    <= 1'b0;
            r_force     <= 1'b0;
            r_forced    <= '0;
            r_last      <= '0;
            r_anim      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_DURATION: r_cfg_dur   <= i_cfg_data[DUR_W-1:0];
                    CFG_FRAME_COUNT:    r_cfg_cnt   <= i_cfg_data[CNT_W-1:0];
                    CFG_FIRST_FRAME:    r_cfg_first <= i_cfg_data[FRM_W-1:0];
                    CFG_REVERSE_DIR:    r_cfg_rev   <= i_cfg_data[0];
                    CFG_PLAY_MODE:      r_cfg_mode  <= i_cfg_data[1:0];
                    CFG_SPEED_SCALE:    r_cfg_speed <= i_cfg_data[SPD_W-1:0];
                    CFG_GRID_COLUMNS:   r_cfg_cols  <= i_cfg_data[COL_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (acc) begin
                unique case (act)
                    ACT_QUERY: begin
                        if (!r_force && r_running) begin
                            r_last <= i_in.sim_time;
                        end
                    end
                    ACT_START: begin
                        r_running <= 1'b1;
                        r_paused  <= 1'b0;
                        r_anim    <= '0;
                        r_last    <= i_in.sim_time;
                    end
                    ACT_STOP: begin
                        r_running <= 1'b0;
                        r_paused  <= 1'b0;
                        r_anim    <= '0;
                        r_last    <= '0;
                    end
                    ACT_PAUSE:     r_paused <= 1'b1;
                    ACT_RESUME:    r_paused <= 1'b0;
                    // The animation time is written once the product is ready.
                    ACT_SET_FRAME: begin
                    end
                    ACT_FORCE: begin
                        r_force  <= 1'b1;
                        r_forced <= i_in.frame_value;
                    end
                    ACT_RELEASE:   r_force <= 1'b0;
                endcase
            end

            if (r_state == ST_ADD) begin
                if (r_set) begin
                    r_anim <= {mul_prod[DIV_W-1:0], FRAC_W'(0)};
                end else if (anim_sum[ANIM_W]) begin
                    r_anim <= '1;
                end else begin
                    r_anim <= anim_sum[ANIM_W-1:0];
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_set <= need_set;
        end
        if (r_state == ST_MODE) begin
            r_m <= m_val;
        end
        if (r_state == ST_FRAME) begin
            r_idx <= f_val;
        end else if (grid_go) begin
            r_idx <= grid_val;
        end
        if (out_load) begin
            r_out_frame <= r_idx;
            r_out_col   <= grid_col;
            r_out_row   <= grid_row;
            r_out_run   <= r_running;
            r_out_pause <= r_paused;
            r_out_force <= r_force;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.frame_index = r_out_frame;
    assign o_out.grid_column = r_out_col;
    assign o_out.grid_row    = r_out_row;
    assign o_out.is_running  = r_out_run;
    assign o_out.is_paused   = r_out_pause;
    assign o_out.is_forcing  = r_out_force;

    // No new event may enter while any serial unit is still working.
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_sts.busy || div_sts.busy || grid_sts.busy) |-> !i_in.ready)
        else $error("event accepted while a serial unit is busy");

    // The streamed remainder stays below its period.
    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODE) |-> (div_mod < d_mod))
        else $error("frame period remainder out of range");

    // A computed frame is always below the frame count.
    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAME) |=> ({1'b0, r_idx} < n_eff))
        else $error("computed frame not below frame count");

    // Advancing time never moves the animation backward.
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && !r_set) |=> (r_anim >= $past(r_anim)))
        else $error("animation time decreased on advance");

endmodule
